### rtl/core/bps_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bps_pkg
// Shared types, codes and constants of the buzzer beep pattern sequencer.
// ----------------------------------------------------------------------------
package bps_pkg;

  // Item function codes
  typedef enum logic [1:0] {
    FN_TICK  = 2'd0,
    FN_START = 2'd1,
    FN_STOP  = 2'd2,
    FN_SETPAT = 2'd3
  } bps_func_t;

  // Pattern codes
  localparam logic [1:0] PAT_SWEEP = 2'd0;
  localparam logic [1:0] PAT_STAIR = 2'd1;

  // Start mode codes
  localparam logic [1:0] MODE_SWEEP     = 2'd0;
  localparam logic [1:0] MODE_STAIR     = 2'd1;
  localparam logic [1:0] MODE_SWEEP_ALT = 2'd2;
  localparam logic [1:0] MODE_HOLD      = 2'd3;

  // Default timing, in ticks
  localparam int LONG_ON_TICKS_DEF     = 500;
  localparam int SHORT_ON_TICKS_DEF    = 60;
  localparam int OFF_TICKS_DEF         = 10;
  localparam int START_DELAY_TICKS_DEF = 3000;

  localparam int WAIT_W  = 10;
  localparam int DELAY_W = 16;
  localparam int FREQ_W  = 12;

  localparam logic [FREQ_W-1:0] FREQ_SWEEP_TOP = 12'd3200;
  localparam logic [FREQ_W-1:0] FREQ_SWEEP_BOT = 12'd2000;
  localparam logic [FREQ_W-1:0] FREQ_STAIR_TOP = 12'd2100;
  localparam logic [FREQ_W-1:0] FREQ_STAIR_BOT = 12'd1900;
  localparam logic [FREQ_W-1:0] FREQ_SWEEP_STEP = 12'd200;
  localparam logic [FREQ_W-1:0] FREQ_STAIR_STEP = 12'd25;

  localparam logic [4:0] TICK_MOD_LAST = 5'd29;
  localparam logic [2:0] REPEAT_LIMIT  = 3'd3;

  typedef struct packed {
    bps_func_t  func;
    logic [1:0] mode;
  } bps_item_t;

  typedef struct packed {
    logic [1:0]        drive;
    logic              active;
    logic              on_phase;
    logic [FREQ_W-1:0] tone_freq;
  } bps_res_t;

  // tick count 0..29: multiple of five
  function automatic logic is_fifth(input logic [4:0] v);
    return (v == 5'd0) || (v == 5'd5) || (v == 5'd10) ||
           (v == 5'd15) || (v == 5'd20) || (v == 5'd25);
  endfunction

  // tick count 0..29: multiple of six
  function automatic logic is_sixth(input logic [4:0] v);
    return (v == 5'd0) || (v == 5'd6) || (v == 5'd12) ||
           (v == 5'd18) || (v == 5'd24);
  endfunction

endpackage

### rtl/core/bps_in_reg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bps_in_reg
// Input register: holds one accepted beat until the sequencer core takes it.
// ----------------------------------------------------------------------------
module bps_in_reg
  import bps_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  logic [1:0] in_func,
  input  logic [1:0] in_mode,
  input  logic      adv,
  output logic      item_vld,
  output bps_item_t item
);

  logic      vld_r;
  logic      vld_nxt;
  bps_item_t item_r;

  assign in_ready = !vld_r || adv;
  assign vld_nxt  = (in_valid && in_ready) || (vld_r && !adv);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r.func <= bps_func_t'(in_func);
      item_r.mode <= in_mode;
    end
  end

  assign item_vld = vld_r;
  assign item     = item_r;

endmodule

### rtl/core/bps_seq_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bps_seq_core
// Sequencer state and its single-pass update for one item per cycle while adv is high.
// ----------------------------------------------------------------------------
module bps_seq_core
  import bps_pkg::*;
#(
  parameter int LONG_ON_TICKS     = LONG_ON_TICKS_DEF,
  parameter int SHORT_ON_TICKS    = SHORT_ON_TICKS_DEF,
  parameter int OFF_TICKS         = OFF_TICKS_DEF,
  parameter int START_DELAY_TICKS = START_DELAY_TICKS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [1:0] cfg_wdata,
  input  logic       adv,
  input  bps_item_t  item,
  output bps_res_t   res
);

  localparam logic [WAIT_W-1:0]  LONG_W  = WAIT_W'(LONG_ON_TICKS);
  localparam logic [WAIT_W-1:0]  SHORT_W = WAIT_W'(SHORT_ON_TICKS);
  localparam logic [WAIT_W-1:0]  OFF_W   = WAIT_W'(OFF_TICKS);
  localparam logic [DELAY_W-1:0] DELAY_V = DELAY_W'(START_DELAY_TICKS);

  logic [1:0]         level_r;
  logic               enabled_r,   enabled_nxt;
  logic               phase_on_r,  phase_on_nxt;
  logic [1:0]         pattern_r,   pattern_nxt;
  logic [WAIT_W-1:0]  wait_r,      wait_nxt;
  logic [2:0]         repeat_r,    repeat_nxt;
  logic [DELAY_W-1:0] delay_r,     delay_nxt;
  logic [FREQ_W-1:0]  freq_r,      freq_nxt;
  logic [FREQ_W-1:0]  top_r,       top_nxt;
  logic [FREQ_W-1:0]  bot_r,       bot_nxt;
  logic               sweep_up_r,  sweep_up_nxt;
  logic [4:0]         tick_mod_r,  tick_mod_nxt;
  logic [1:0]         pins_r,      pins_nxt;

  // Signed working copies, wide enough for +-200 around a 12-bit tone
  logic signed [FREQ_W+1:0] f_up, f_dn, f_stair, bot_s, top_s;
  logic [WAIT_W-1:0]        wait_dec;
  logic [4:0]               tick_inc;
  logic [2:0]               repeat_inc;

  assign f_up     = $signed({2'b00, freq_r}) + $signed({2'b00, FREQ_SWEEP_STEP});
  assign f_dn     = $signed({2'b00, freq_r}) - $signed({2'b00, FREQ_SWEEP_STEP});
  assign f_stair  = $signed({2'b00, freq_r}) - $signed({2'b00, FREQ_STAIR_STEP});
  assign bot_s    = $signed({2'b00, bot_r});
  assign top_s    = $signed({2'b00, top_r});
  assign wait_dec = wait_r - 1'b1;
  assign tick_inc = (tick_mod_r == TICK_MOD_LAST) ? 5'd0 : tick_mod_r + 5'd1;
  assign repeat_inc = repeat_r + 3'd1;

  always_comb begin
    enabled_nxt  = enabled_r;
    phase_on_nxt = phase_on_r;
    pattern_nxt  = pattern_r;
    wait_nxt     = wait_r;
    repeat_nxt   = repeat_r;
    delay_nxt    = delay_r;
    freq_nxt     = freq_r;
    top_nxt      = top_r;
    bot_nxt      = bot_r;
    sweep_up_nxt = sweep_up_r;
    tick_mod_nxt = tick_mod_r;
    pins_nxt     = pins_r;

    unique case (item.func)
      FN_TICK: begin
        if (enabled_r) begin
          if (delay_r != '0) begin
            // negative delay never elapses
            if (!delay_r[DELAY_W-1]) begin
              delay_nxt = delay_r - 1'b1;
            end
          end else if (wait_r != '0) begin
            wait_nxt = wait_dec;
            if (phase_on_r) begin
              tick_mod_nxt = tick_inc;
              if (pattern_r == PAT_SWEEP && is_fifth(tick_inc)) begin
                pins_nxt = level_r;
                if (!sweep_up_r) begin
                  if (f_dn <= bot_s) begin
                    sweep_up_nxt = 1'b1;
                    freq_nxt     = bot_r;
                  end else begin
                    freq_nxt = f_dn[FREQ_W-1:0];
                  end
                end else begin
                  if (f_up >= top_s) begin
                    sweep_up_nxt = 1'b0;
                    freq_nxt     = top_r;
                  end else begin
                    freq_nxt = f_up[FREQ_W-1:0];
                  end
                end
              end else if (pattern_r == PAT_STAIR && is_sixth(tick_inc)) begin
                pins_nxt = level_r;
                freq_nxt = (f_stair <= bot_s) ? top_r : f_stair[FREQ_W-1:0];
              end
              if (wait_dec == '0) begin
                pins_nxt     = 2'b00;
                phase_on_nxt = 1'b0;
                wait_nxt     = OFF_W;
              end
            end else begin
              pins_nxt = 2'b00;
              if (wait_dec == '0) begin
                phase_on_nxt = 1'b1;
                if (pattern_r == PAT_SWEEP) begin
                  wait_nxt = LONG_W;
                end else if (pattern_r == PAT_STAIR) begin
                  wait_nxt   = SHORT_W;
                  repeat_nxt = repeat_inc;
                  freq_nxt   = FREQ_STAIR_TOP;
                  // fourth repeat done: stop (countdown already zero)
                  if (repeat_inc > REPEAT_LIMIT) begin
                    wait_nxt    = '0;
                    repeat_nxt  = '0;
                    enabled_nxt = 1'b0;
                  end
                end
              end
            end
          end
        end
      end
      FN_START: begin
        phase_on_nxt = 1'b1;
        enabled_nxt  = 1'b1;
        pins_nxt     = pins_r | level_r;
        if (item.mode == MODE_SWEEP || item.mode == MODE_SWEEP_ALT) begin
          pattern_nxt = PAT_SWEEP;
          freq_nxt    = FREQ_SWEEP_TOP;
          top_nxt     = FREQ_SWEEP_TOP;
          bot_nxt     = FREQ_SWEEP_BOT;
          wait_nxt    = LONG_W;
          delay_nxt   = '0;
        end else if (item.mode == MODE_STAIR) begin
          pattern_nxt = PAT_STAIR;
          freq_nxt    = FREQ_STAIR_TOP;
          top_nxt     = FREQ_STAIR_TOP;
          bot_nxt     = FREQ_STAIR_BOT;
          wait_nxt    = SHORT_W;
          delay_nxt   = DELAY_V;
        end
      end
      FN_STOP: begin
        if (wait_r != '0) begin
          wait_nxt = '0;
          pins_nxt = 2'b00;
        end
        enabled_nxt = 1'b0;
      end
      FN_SETPAT: begin
        pattern_nxt = item.mode;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r <= 2'd3;
    end else if (cfg_we) begin
      level_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enabled_r  <= 1'b0;
      phase_on_r <= 1'b0;
      pattern_r  <= PAT_SWEEP;
      wait_r     <= '0;
      repeat_r   <= '0;
      delay_r    <= '1;
      freq_r     <= FREQ_STAIR_TOP;
      top_r      <= FREQ_STAIR_TOP;
      bot_r      <= FREQ_STAIR_BOT;
      sweep_up_r <= 1'b0;
      tick_mod_r <= '0;
      pins_r     <= 2'b00;
    end else if (adv) begin
      enabled_r  <= enabled_nxt;
      phase_on_r <= phase_on_nxt;
      pattern_r  <= pattern_nxt;
      wait_r     <= wait_nxt;
      repeat_r   <= repeat_nxt;
      delay_r    <= delay_nxt;
      freq_r     <= freq_nxt;
      top_r      <= top_nxt;
      bot_r      <= bot_nxt;
      sweep_up_r <= sweep_up_nxt;
      tick_mod_r <= tick_mod_nxt;
      pins_r     <= pins_nxt;
    end
  end

  assign res.drive     = pins_nxt;
  assign res.active    = enabled_nxt;
  assign res.on_phase  = phase_on_nxt;
  assign res.tone_freq = freq_nxt;

endmodule

### rtl/core/bps_out_reg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bps_out_reg
// Result register: holds one result beat until the consumer takes it.
// ----------------------------------------------------------------------------
module bps_out_reg
  import bps_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              adv,
  input  bps_res_t          res,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [1:0]        out_drive,
  output logic              out_active,
  output logic              out_on_phase,
  output logic [FREQ_W-1:0] out_tone_freq
);

  logic     vld_r;
  logic     vld_nxt;
  bps_res_t res_r;

  assign vld_nxt = adv || (vld_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res_r <= res;
    end
  end

  assign out_valid     = vld_r;
  assign out_drive     = res_r.drive;
  assign out_active    = res_r.active;
  assign out_on_phase  = res_r.on_phase;
  assign out_tone_freq = res_r.tone_freq;

endmodule

### rtl/core/beep_pattern_sequencer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// beep_pattern_sequencer
// Buzzer alarm sequencer: ticks and commands in, pin levels and tone out.
// ----------------------------------------------------------------------------
// Takes one beat per cycle while the result side is not stalled and returns
// one result beat for each, in order. A beat lands in the input register;
// the core then updates its state and loads the result register, which
// offers the result when the output is free. The single-pass state update in
// the core sets the rate of one beat per cycle. cfg_wdata sets the drive
// level (1 pin A, 2 pin B, 3 both) and should only be written while idle.
module beep_pattern_sequencer
  import bps_pkg::*;
#(
  parameter int LONG_ON_TICKS     = LONG_ON_TICKS_DEF,
  parameter int SHORT_ON_TICKS    = SHORT_ON_TICKS_DEF,
  parameter int OFF_TICKS         = OFF_TICKS_DEF,
  parameter int START_DELAY_TICKS = START_DELAY_TICKS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_wdata,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        in_func,
  input  logic [1:0]        in_mode,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [1:0]        out_drive,
  output logic              out_active,
  output logic              out_on_phase,
  output logic [FREQ_W-1:0] out_tone_freq
);

  logic      item_vld;
  bps_item_t item;
  bps_res_t  res;
  logic      adv;

  // core moves a beat when one is held and the result slot frees up
  assign adv = item_vld && (!out_valid || out_ready);

  bps_in_reg u_in_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_func  (in_func),
    .in_mode  (in_mode),
    .adv      (adv),
    .item_vld (item_vld),
    .item     (item)
  );

  bps_seq_core #(
    .LONG_ON_TICKS     (LONG_ON_TICKS),
    .SHORT_ON_TICKS    (SHORT_ON_TICKS),
    .OFF_TICKS         (OFF_TICKS),
    .START_DELAY_TICKS (START_DELAY_TICKS)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .adv       (adv),
    .item      (item),
    .res       (res)
  );

  bps_out_reg u_out_reg (
    .clk           (clk),
    .rst_n         (rst_n),
    .adv           (adv),
    .res           (res),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_drive     (out_drive),
    .out_active    (out_active),
    .out_on_phase  (out_on_phase),
    .out_tone_freq (out_tone_freq)
  );

`ifndef NO_ASSERTIONS
  // pins only sound in the on phase
  a_drive_on_phase: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_drive != 2'b00) |-> out_on_phase)
    else $error("drive active outside on phase");

  // tone never leaves the stair/sweep band
  a_freq_band: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_tone_freq >= FREQ_STAIR_BOT) && (out_tone_freq <= FREQ_SWEEP_TOP))
    else $error("tone outside band");

  // an accepted beat is held in the input register next cycle
  a_accept_held: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> item_vld)
    else $error("accepted beat lost");

  // a stalled result blocks the input only when a beat is waiting
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> item_vld && out_valid && !out_ready)
    else $error("input stalled without cause");
`endif

endmodule
